>>> src/lpcc_pkg.sv
// shared types, constants and helpers for the coefficient codec
`timescale 1ns / 1ps

package lpcc_pkg;

  localparam int QueueDepth = 2;

  localparam int AccW  = 20;
  localparam int CntW  = 5;
  localparam int DataW = 24;

  typedef enum logic [2:0] {
    MODE_PACK13     = 3'd0,
    MODE_UNPACK13   = 3'd1,
    MODE_COMPRESS3  = 3'd2,
    MODE_DECOMPRESS = 3'd3,
    MODE_TO_MSG     = 3'd4,
    MODE_FROM_MSG   = 3'd5
  } mode_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    mode_t             kind;
    logic [2:0]        last_idx;
    logic [DataW-1:0]  data;
  } job_t;

  localparam logic signed [13:0] CoefQ    = 14'sd7681;
  localparam logic        [13:0] CoefHalf = 14'd3841;
  localparam logic        [12:0] CenterLim = 13'd3840;

  // (t * q + 4) >> 3 for a 3-bit t
  function automatic logic [13:0] decomp3(input logic [2:0] t);
    logic [13:0] r;
    case (t)
      3'd0:    r = 14'd0;
      3'd1:    r = 14'd960;
      3'd2:    r = 14'd1920;
      3'd3:    r = 14'd2880;
      3'd4:    r = 14'd3841;
      3'd5:    r = 14'd4801;
      3'd6:    r = 14'd5761;
      3'd7:    r = 14'd6721;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/lpcc_front.sv
// front end: holds mode and bit accumulator, turns input words into jobs (some words give none)
`timescale 1ns / 1ps

module lpcc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_wr_data,
  input  logic                      item_take,
  input  logic signed [13:0]        in_coeff,
  input  logic [7:0]                in_byte,
  output lpcc_pkg::job_t            job,
  output logic                      job_has
);
  import lpcc_pkg::*;

  mode_t             mode_r;
  logic [AccW-1:0]   acc_r, acc_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  logic signed [13:0] coef_l;
  logic signed [17:0] x2;
  logic signed [35:0] p2;
  logic signed [15:0] x4;
  logic signed [32:0] p4;
  logic [2:0]         d3;
  logic               m1;
  logic [AccW-1:0]    acc_sh, acc_or;

  localparam logic signed [17:0] KComp = 18'sd69895;
  localparam logic signed [16:0] KMsg  = 17'sd34947;
  localparam logic signed [17:0] RndC  = 18'sd3841;
  localparam logic signed [15:0] RndM  = 16'sd3841;

  // lift negatives by q once
  assign coef_l = in_coeff[13] ? in_coeff + CoefQ : in_coeff;

  // rounding multiplies, only the low 32 bits of the product matter
  assign x2 = {coef_l[13], coef_l, 3'b000} + RndC;
  assign p2 = x2 * KComp;
  assign d3 = p2[31:29];
  assign x4 = {coef_l[13], coef_l, 1'b0} + RndM;
  assign p4 = x4 * KMsg;
  assign m1 = p4[28];

  always_comb begin
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    job.kind     = mode_r;
    job.last_idx = 3'd0;
    job.data     = '0;
    job_has      = 1'b0;
    acc_sh       = '0;
    acc_or       = '0;
    case (mode_r)
      MODE_PACK13: begin
        acc_sh  = {acc_r[6:0], coef_l[12:0]};
        acc_nxt = acc_sh;
        job_has = 1'b1;
        job.data[7:0] = 8'(acc_sh >> (cnt_r + 5'd5));
        if (cnt_r >= 5'd3) begin
          job.data[15:8] = 8'(acc_sh >> (cnt_r - 5'd3));
          job.last_idx   = 3'd1;
          cnt_nxt        = cnt_r - 5'd3;
        end else begin
          cnt_nxt = cnt_r + 5'd5;
        end
      end
      MODE_UNPACK13: begin
        acc_sh  = {acc_r[11:0], in_byte};
        acc_nxt = acc_sh;
        if (cnt_r >= 5'd5) begin
          job_has        = 1'b1;
          job.data[12:0] = 13'(acc_sh >> (cnt_r - 5'd5));
          cnt_nxt        = cnt_r - 5'd5;
        end else begin
          cnt_nxt = cnt_r + 5'd8;
        end
      end
      MODE_COMPRESS3: begin
        acc_or = acc_r | (AccW'(d3) << cnt_r[3:0]);
        if (cnt_r >= 5'd5) begin
          job_has       = 1'b1;
          job.data[7:0] = acc_or[7:0];
          acc_nxt       = acc_or >> 8;
          cnt_nxt       = cnt_r - 5'd5;
        end else begin
          acc_nxt = acc_or;
          cnt_nxt = cnt_r + 5'd3;
        end
      end
      MODE_DECOMPRESS: begin
        acc_or        = acc_r | (AccW'(in_byte) << cnt_r[2:0]);
        job_has       = 1'b1;
        job.data[8:0] = acc_or[8:0];
        if (cnt_r == 5'd0) begin
          // eight bits give two values, two bits left over
          job.last_idx = 3'd1;
          acc_nxt      = acc_or >> 6;
          cnt_nxt      = 5'd2;
        end else begin
          job.last_idx = 3'd2;
          acc_nxt      = acc_or >> 9;
          cnt_nxt      = cnt_r - 5'd1;
        end
      end
      MODE_TO_MSG: begin
        acc_or = acc_r | (AccW'(m1) << cnt_r[2:0]);
        if (cnt_r == 5'd7) begin
          job_has       = 1'b1;
          job.data[7:0] = acc_or[7:0];
          acc_nxt       = '0;
          cnt_nxt       = '0;
        end else begin
          acc_nxt = acc_or;
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      MODE_FROM_MSG: begin
        job_has       = 1'b1;
        job.last_idx  = 3'd7;
        job.data[7:0] = in_byte;
      end
      default: begin
        job_has = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PACK13;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wr_data);
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (item_take) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/lpcc_queue.sv
// small job queue between front and back
`timescale 1ns / 1ps

module lpcc_queue #(
  parameter int DEPTH = lpcc_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpcc_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output lpcc_pkg::job_t head
);
  import lpcc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/lpcc_back.sv
// back end: walks a job one result word per cycle into the output register while out_stall is low
`timescale 1ns / 1ps

module lpcc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_ready,
  input  lpcc_pkg::job_t     job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic signed [13:0] out_coeff,
  output logic               out_last
);
  import lpcc_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_val;
  logic [13:0] coeff_r, coeff_val;
  logic        last_r, last_val;
  logic        load;
  logic [12:0] t13;
  logic [2:0]  t3;
  logic        bit_v;

  assign load = job_ready && (!valid_r || !out_stall);
  assign pop  = load && last_val;

  always_comb begin
    byte_val  = '0;
    coeff_val = '0;
    last_val  = (idx_r == job.last_idx);
    t13       = job.data[12:0];
    t3        = 3'(job.data >> (5'(idx_r) * 5'd3));
    bit_v     = 1'(job.data >> idx_r);
    case (job.kind)
      MODE_PACK13, MODE_COMPRESS3, MODE_TO_MSG: begin
        byte_val = 8'(job.data >> {idx_r[1:0], 3'b000});
      end
      MODE_UNPACK13: begin
        // centre to the symmetric range
        coeff_val = (t13 > CenterLim) ? 14'(t13) - 14'(CoefQ) : 14'(t13);
      end
      MODE_DECOMPRESS: begin
        coeff_val = decomp3(t3);
      end
      MODE_FROM_MSG: begin
        coeff_val = bit_v ? CoefHalf : 14'd0;
      end
      default: begin
        coeff_val = '0;
      end
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = out_stall ? valid_r : 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_val ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_val;
      coeff_r <= coeff_val;
      last_r  <= last_val;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_coeff = coeff_r;
  assign out_last  = last_r;

endmodule

>>> src/lattice_poly_coefficient_codec_unit.sv
// top level of the polynomial coefficient codec (mod 7681)
`timescale 1ns / 1ps
// Usage:
//   cfg_wr_en / cfg_wr_data write the mode (0 pack13, 1 unpack13, 2 compress3,
//   3 decompress3, 4 to message bits, 5 from message bits); each write also
//   empties the bit accumulator. Write only while the block is idle.
//   Input words (in_coeff, in_byte) are taken when in_valid is high and
//   in_stall low. Each word yields zero to eight result words on
//   out_byte / out_coeff, taken when out_valid is high and out_stall low;
//   out_last marks the final result word of an input word.
// Path: the first result of a word goes through the queue slot and then
//   the output register of the back end before it reaches the output.
// Throughput: one result word per cycle while out_stall is low, set by the
//   output register in the back end; a word with one result or none goes in
//   every cycle, a word with k results holds the back end for k result
//   words (8 in mode 5, up to 3 in mode 3, up to 2 in mode 0).
// The front end classifies a word in its accept cycle and drops a job into a
//   two-entry queue; in_stall rises only when that queue is full.
// Under out_stall the output word holds; the queue fills and then stalls
//   the input side.
// Reset (rst_n low, synchronous) sets mode 0, empties accumulator, queue
//   and output register.

module lattice_poly_coefficient_codec_unit #(
  parameter int QUEUE_DEPTH = lpcc_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [13:0] in_coeff,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic signed [13:0] out_coeff,
  output logic               out_last
);
  import lpcc_pkg::*;

  job_t new_job, head_job;
  logic new_has, take, q_full, q_ne, q_pop;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  lpcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_take   (take),
    .in_coeff    (in_coeff),
    .in_byte     (in_byte),
    .job         (new_job),
    .job_has     (new_has)
  );

  lpcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && new_has),
    .push_job  (new_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_ne),
    .head      (head_job)
  );

  lpcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_ready (q_ne),
    .job       (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_coeff (out_coeff),
    .out_last  (out_last)
  );

endmodule
